// ===== design/utrsf_pkg.sv =====
// Shared widths, limits, codes and stage structs of the up-the-ramp slope fit.
`default_nettype none
package utrsf_pkg;

   // Limits of the frame and the ramp
   localparam int MAX_PIXELS = 65536;
   localparam int MAX_READS  = 256;

   // Field and state widths
   localparam int SAMPLE_W = 16;
   localparam int TIME_W   = 16;
   localparam int PIX_W    = $clog2(MAX_PIXELS);
   localparam int PCNT_W   = PIX_W + 1;
   localparam int RPOS_W   = $clog2(MAX_READS);
   localparam int RCNT_W   = RPOS_W + 1;
   localparam int SS_W     = 24;
   localparam int TSS_W    = 40;
   localparam int TS_W     = 24;
   localparam int TSQ_W    = 40;
   localparam int PROD_W   = SAMPLE_W + TIME_W;
   localparam int SPAN_W   = TIME_W + 1;
   localparam int SLOPE_W  = 32;
   localparam int CSR_W    = PCNT_W;

   // Fit datapath widths
   localparam int P1_W   = RCNT_W + TSS_W;
   localparam int P2_W   = TS_W + SS_W;
   localparam int NUM_W  = P1_W + 1;
   localparam int MAG_W  = NUM_W - 1;
   localparam int K_W    = TIME_W + 8;
   localparam int MLO_W  = 25;
   localparam int MHI_W  = MAG_W - MLO_W;
   localparam int PA_W   = MLO_W + K_W;
   localparam int PB_W   = MHI_W + K_W;
   localparam int X_W    = MAG_W + K_W;
   localparam int QUO_W  = SLOPE_W;
   localparam int DD_W   = MAG_W + QUO_W;

   // Register indexes
   typedef enum logic [0:0] {
      CSR_PIXEL_COUNT = 1'b0,
      CSR_READ_COUNT  = 1'b1
   } csr_index_type;

   // One pixel's sums and ramp terms entering the fit
   typedef struct packed {
      logic                     valid;
      logic [TSS_W-1:0]         sts;
      logic [SS_W-1:0]          ss;
      logic [RCNT_W-1:0]        n;
      logic [TS_W-1:0]          ts;
      logic [TSQ_W-1:0]         tsq;
      logic [SPAN_W-1:0]        span;
      logic [PIX_W-1:0]         pixel;
      logic                     frame_end;
   } fit_in_type;

   // One finished result
   typedef struct packed {
      logic                     valid;
      logic [PIX_W-1:0]         pixel;
      logic [SLOPE_W-1:0]       slope;
      logic                     bad;
      logic                     frame_end;
   } fit_out_type;

   // Tag that travels along the fit pipeline
   typedef struct packed {
      logic                     valid;
      logic [PIX_W-1:0]         pixel;
      logic                     frame_end;
   } tag_type;

endpackage
`default_nettype wire

// ===== design/utrsf_if.sv =====
// Request and response channel interfaces of the slope fit.
`default_nettype none
interface utrsf_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] sample_value;
   logic [15:0] read_time;
   modport source (output valid, output sample_value, output read_time, input ready);
   modport sink (input valid, input sample_value, input read_time, output ready);
endinterface

interface utrsf_rsp_if;
   logic               valid;
   logic               ready;
   logic [15:0]        pixel_number;
   logic signed [31:0] scaled_slope;
   logic               bad_fit;
   logic               frame_end;
   modport source (output valid, output pixel_number, output scaled_slope,
                   output bad_fit, output frame_end, input ready);
   modport sink (input valid, input pixel_number, input scaled_slope,
                 input bad_fit, input frame_end, output ready);
endinterface
`default_nettype wire

// ===== design/up_the_ramp_slope_fit.sv =====
// Top level of the up-the-ramp slope fit: sequencing, per-pixel accumulation memory, fit pipeline.
//
//   channel  direction  transaction
//   req      in         sample_value, read_time: one pixel of one read
//   rsp      out        pixel_number, scaled_slope, bad_fit, frame_end
//   csr      in         write of pixel_count (index 0) or read_count (index 1)
//
// One sample per clock while the pipeline advances; the pixel sums live in one 64-bit wide
// memory read as a sample is accepted and written back from the accumulate stage, with a
// bypass for a pixel that follows itself.
// The whole pipeline halts while a result waits in the output register.
// Reset clears counters, ramp sums and valid bits; no memory sweep is needed.
`default_nettype none
module up_the_ramp_slope_fit import utrsf_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   utrsf_req_if.sink         req,
   utrsf_rsp_if.source       rsp,
   input  logic              csr_write_enable,
   input  logic [0:0]        csr_index,
   input  logic [CSR_W-1:0]  csr_write_data
);

   localparam int ENTRY_W = TSS_W + SS_W;

   logic [PCNT_W-1:0]  pixel_count_ff;
   logic [RCNT_W-1:0]  read_count_ff;
   logic [PCNT_W-1:0]  eff_pixels;
   logic [RCNT_W-1:0]  eff_reads;

   logic [PIX_W-1:0]   pixel_position_ff, pixel_position_in;
   logic [RPOS_W-1:0]  read_position_ff, read_position_in;
   logic [TIME_W-1:0]  cur_time_ff, cur_time_in;
   logic [TIME_W-1:0]  first_time_ff, first_time_in;
   logic [TS_W-1:0]    time_sum_ff, time_sum_in;
   logic [TSQ_W-1:0]   time_sq_sum_ff, time_sq_sum_in;

   logic               advance, accept, first_pixel, first_read, last_pixel, last_read;
   logic [PROD_W-1:0]  time_sq;

   logic               s1_valid_ff;
   logic [PIX_W-1:0]   s1_addr_ff;
   logic [SAMPLE_W-1:0] s1_sample_ff;
   logic [PROD_W-1:0]  s1_prod_ff;
   logic               s1_first_ff, s1_last_read_ff, s1_last_pixel_ff;
   logic [RCNT_W-1:0]  s1_n_ff;
   logic [TS_W-1:0]    s1_ts_ff;
   logic [TSQ_W-1:0]   s1_tsq_ff;
   logic [SPAN_W-1:0]  s1_span_ff;

   logic [ENTRY_W-1:0] acc_mem [MAX_PIXELS];
   logic [ENTRY_W-1:0] rd_ff, fwd_ff, old_entry, new_entry;
   logic               fwd_valid_ff;
   logic [PIX_W-1:0]   fwd_addr_ff;
   logic [SS_W-1:0]    new_ss;
   logic [TSS_W-1:0]   new_tss;

   fit_in_type         fit_in;
   fit_out_type        fit_out;

   // Take register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_count_ff <= PCNT_W'(MAX_PIXELS);
         read_count_ff  <= RCNT_W'(2);
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_PIXEL_COUNT: pixel_count_ff <= csr_write_data;
            CSR_READ_COUNT:  read_count_ff  <= csr_write_data[RCNT_W-1:0];
            default: ;
         endcase
      end
   end

   // Clamp the counts to their working range
   always_comb begin
      if (pixel_count_ff == '0) eff_pixels = PCNT_W'(1);
      else if (pixel_count_ff > PCNT_W'(MAX_PIXELS)) eff_pixels = PCNT_W'(MAX_PIXELS);
      else eff_pixels = pixel_count_ff;
      if (read_count_ff < RCNT_W'(2)) eff_reads = RCNT_W'(2);
      else if (read_count_ff > RCNT_W'(MAX_READS)) eff_reads = RCNT_W'(MAX_READS);
      else eff_reads = read_count_ff;
   end

   assign advance   = !fit_out.valid || rsp.ready;
   assign req.ready = advance;
   assign accept    = req.valid && advance;

   // Sequence pixels and reads, update the ramp sums
   always_comb begin
      first_pixel    = pixel_position_ff == '0;
      first_read     = read_position_ff == '0;
      last_pixel     = (PCNT_W'(pixel_position_ff) + PCNT_W'(1)) >= eff_pixels;
      last_read      = (RCNT_W'(read_position_ff) + RCNT_W'(1)) >= eff_reads;
      time_sq        = req.read_time * req.read_time;
      cur_time_in    = cur_time_ff;
      first_time_in  = first_time_ff;
      time_sum_in    = time_sum_ff;
      time_sq_sum_in = time_sq_sum_ff;
      if (first_pixel) begin
         cur_time_in = req.read_time;
         if (first_read) begin
            first_time_in  = req.read_time;
            time_sum_in    = TS_W'(req.read_time);
            time_sq_sum_in = TSQ_W'(time_sq);
         end else begin
            time_sum_in    = time_sum_ff + TS_W'(req.read_time);
            time_sq_sum_in = time_sq_sum_ff + TSQ_W'(time_sq);
         end
      end
      pixel_position_in = last_pixel ? '0 : pixel_position_ff + PIX_W'(1);
      read_position_in  = read_position_ff;
      if (last_pixel) read_position_in = last_read ? '0 : read_position_ff + RPOS_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_position_ff <= '0;
         read_position_ff  <= '0;
         cur_time_ff       <= '0;
         first_time_ff     <= '0;
         time_sum_ff       <= '0;
         time_sq_sum_ff    <= '0;
      end else if (accept) begin
         pixel_position_ff <= pixel_position_in;
         read_position_ff  <= read_position_in;
         cur_time_ff       <= cur_time_in;
         first_time_ff     <= first_time_in;
         time_sum_ff       <= time_sum_in;
         time_sq_sum_ff    <= time_sq_sum_in;
      end
   end

   // Capture the accepted sample into the accumulate stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_addr_ff       <= pixel_position_ff;
         s1_sample_ff     <= req.sample_value;
         s1_prod_ff       <= cur_time_in * req.sample_value;
         s1_first_ff      <= first_read;
         s1_last_read_ff  <= last_read;
         s1_last_pixel_ff <= last_pixel;
         s1_n_ff          <= RCNT_W'(read_position_ff) + RCNT_W'(1);
         s1_ts_ff         <= time_sum_in;
         s1_tsq_ff        <= time_sq_sum_in;
         s1_span_ff       <= SPAN_W'(cur_time_in) - SPAN_W'(first_time_in);
      end
   end

   // Pixel sums memory: read on accept, write back from the accumulate stage
   always_ff @(posedge clock) begin
      if (advance && s1_valid_ff) begin
         acc_mem[s1_addr_ff] <= new_entry;
      end
      if (accept) begin
         rd_ff <= acc_mem[pixel_position_ff];
      end
   end

   // Remember the write of the last advancing edge for the bypass
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_valid_ff <= 1'b0;
      end else if (advance) begin
         fwd_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         fwd_addr_ff <= s1_addr_ff;
         fwd_ff      <= new_entry;
      end
   end

   // Accumulate: restart on the first read, else add onto the stored sums
   always_comb begin
      old_entry = (fwd_valid_ff && (fwd_addr_ff == s1_addr_ff)) ? fwd_ff : rd_ff;
      if (s1_first_ff) begin
         new_ss  = SS_W'(s1_sample_ff);
         new_tss = TSS_W'(s1_prod_ff);
      end else begin
         new_ss  = old_entry[SS_W-1:0] + SS_W'(s1_sample_ff);
         new_tss = old_entry[ENTRY_W-1:SS_W] + TSS_W'(s1_prod_ff);
      end
      new_entry = {new_tss, new_ss};

      fit_in.valid     = s1_valid_ff && s1_last_read_ff;
      fit_in.sts       = new_tss;
      fit_in.ss        = new_ss;
      fit_in.n         = s1_n_ff;
      fit_in.ts        = s1_ts_ff;
      fit_in.tsq       = s1_tsq_ff;
      fit_in.span      = s1_span_ff;
      fit_in.pixel     = s1_addr_ff;
      fit_in.frame_end = s1_last_pixel_ff;
   end

   utrsf_fit u_fit (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .fit_in  (fit_in),
      .fit_out (fit_out)
   );

   // Drive the response channel from the result register
   assign rsp.valid        = fit_out.valid;
   assign rsp.pixel_number = fit_out.pixel;
   assign rsp.scaled_slope = fit_out.slope;
   assign rsp.bad_fit      = fit_out.bad;
   assign rsp.frame_end    = fit_out.frame_end;

endmodule
`default_nettype wire

// ===== design/utrsf_fit.sv =====
// Pipelined least-squares fit: products, differences, scaling, long division, saturation.
`default_nettype none
module utrsf_fit import utrsf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        advance,
   input  fit_in_type  fit_in,
   output fit_out_type fit_out
);

   fit_in_type f0_ff;

   tag_type            f1_tag_ff, f2_tag_ff, f3_tag_ff, f4_tag_ff, f5_tag_ff, f6_tag_ff;
   logic [P1_W-1:0]    p1_ff, p3_ff;
   logic [P2_W-1:0]    p2_ff, p4_ff;
   logic [SPAN_W-1:0]  f1_span_ff, f2_span_ff;
   logic [NUM_W-1:0]   num_ff, den_ff;
   logic [MAG_W-1:0]   mag_ff;
   logic [K_W-1:0]     k_ff;
   logic [MAG_W-1:0]   f3_d_ff, f4_d_ff, f5_d_ff, f6_d_ff;
   logic               f3_neg_ff, f4_neg_ff, f5_neg_ff, f6_neg_ff;
   logic               f3_bad_ff, f4_bad_ff, f5_bad_ff, f6_bad_ff;
   logic [PA_W-1:0]    pa_ff;
   logic [PB_W-1:0]    pb_ff;
   logic [X_W-1:0]     x_ff, f6_r_ff;
   logic               f6_big_ff;

   tag_type            dv_tag_ff [QUO_W];
   logic [X_W-1:0]     dv_r_ff   [QUO_W];
   logic [QUO_W-1:0]   dv_q_ff   [QUO_W];
   logic [MAG_W-1:0]   dv_d_ff   [QUO_W];
   logic               dv_neg_ff [QUO_W];
   logic               dv_bad_ff [QUO_W];
   logic               dv_big_ff [QUO_W];

   logic [SPAN_W-1:0]  span_abs;
   logic [NUM_W-1:0]   num_abs;
   logic [SLOPE_W-1:0] slope_in;
   fit_out_type        out_ff;

   // Absolute values for the scaling stage
   always_comb begin
      span_abs = f2_span_ff[SPAN_W-1] ? (~f2_span_ff + SPAN_W'(1)) : f2_span_ff;
      num_abs  = num_ff[NUM_W-1] ? (~num_ff + NUM_W'(1)) : num_ff;
   end

   // Advance products, differences and scaling; clear the valid bits on reset
   always_ff @(posedge clock) begin
      if (reset) begin
         f0_ff.valid     <= 1'b0;
         f1_tag_ff.valid <= 1'b0;
         f2_tag_ff.valid <= 1'b0;
         f3_tag_ff.valid <= 1'b0;
         f4_tag_ff.valid <= 1'b0;
         f5_tag_ff.valid <= 1'b0;
         f6_tag_ff.valid <= 1'b0;
      end else if (advance) begin
         f0_ff <= fit_in;

         // products of the numerator and denominator
         p1_ff <= f0_ff.n * f0_ff.sts;
         p2_ff <= f0_ff.ts * f0_ff.ss;
         p3_ff <= f0_ff.n * f0_ff.tsq;
         p4_ff <= f0_ff.ts * f0_ff.ts;
         f1_span_ff <= f0_ff.span;
         f1_tag_ff  <= {f0_ff.valid, f0_ff.pixel, f0_ff.frame_end};

         // numerator and denominator
         num_ff <= NUM_W'(p1_ff) - NUM_W'(p2_ff);
         den_ff <= NUM_W'(p3_ff) - NUM_W'(p4_ff);
         f2_span_ff <= f1_span_ff;
         f2_tag_ff  <= f1_tag_ff;

         // magnitudes, sign and fit check
         mag_ff    <= num_abs[MAG_W-1:0];
         k_ff      <= {span_abs[TIME_W-1:0], 8'b0};
         f3_neg_ff <= num_ff[NUM_W-1] ^ f2_span_ff[SPAN_W-1];
         f3_bad_ff <= den_ff[NUM_W-1] || (den_ff == '0);
         f3_d_ff   <= den_ff[MAG_W-1:0];
         f3_tag_ff <= f2_tag_ff;

         // partial products of magnitude times scaled span
         pa_ff     <= mag_ff[MLO_W-1:0] * k_ff;
         pb_ff     <= mag_ff[MAG_W-1:MLO_W] * k_ff;
         f4_d_ff   <= f3_d_ff;
         f4_neg_ff <= f3_neg_ff;
         f4_bad_ff <= f3_bad_ff;
         f4_tag_ff <= f3_tag_ff;

         // combine into the dividend
         x_ff      <= X_W'(pa_ff) + {pb_ff, MLO_W'(0)};
         f5_d_ff   <= f4_d_ff;
         f5_neg_ff <= f4_neg_ff;
         f5_bad_ff <= f4_bad_ff;
         f5_tag_ff <= f4_tag_ff;

         // quotient too large for 32 bits
         f6_big_ff <= DD_W'(x_ff) >= {f5_d_ff, QUO_W'(0)};
         f6_r_ff   <= x_ff;
         f6_d_ff   <= f5_d_ff;
         f6_neg_ff <= f5_neg_ff;
         f6_bad_ff <= f5_bad_ff;
         f6_tag_ff <= f5_tag_ff;
      end
   end

   // Restoring division, one quotient bit per stage, top bit first
   always_ff @(posedge clock) begin
      logic [X_W-1:0]   r_src;
      logic [QUO_W-1:0] q_src;
      logic [MAG_W-1:0] d_src;
      logic [DD_W-1:0]  dd;
      if (reset) begin
         for (int j = 0; j < QUO_W; j++) begin
            dv_tag_ff[j].valid <= 1'b0;
         end
      end else if (advance) begin
         for (int j = 0; j < QUO_W; j++) begin
            r_src = (j == 0) ? f6_r_ff : dv_r_ff[j-1];
            q_src = (j == 0) ? '0 : dv_q_ff[j-1];
            d_src = (j == 0) ? f6_d_ff : dv_d_ff[j-1];
            dd    = DD_W'(d_src) << (QUO_W - 1 - j);
            if (DD_W'(r_src) >= dd) begin
               dv_r_ff[j] <= r_src - dd[X_W-1:0];
               dv_q_ff[j] <= q_src | (QUO_W'(1) << (QUO_W - 1 - j));
            end else begin
               dv_r_ff[j] <= r_src;
               dv_q_ff[j] <= q_src;
            end
            dv_d_ff[j] <= d_src;
            if (j == 0) begin
               dv_neg_ff[j] <= f6_neg_ff;
               dv_bad_ff[j] <= f6_bad_ff;
               dv_big_ff[j] <= f6_big_ff;
               dv_tag_ff[j] <= f6_tag_ff;
            end else begin
               dv_neg_ff[j] <= dv_neg_ff[j-1];
               dv_bad_ff[j] <= dv_bad_ff[j-1];
               dv_big_ff[j] <= dv_big_ff[j-1];
               dv_tag_ff[j] <= dv_tag_ff[j-1];
            end
         end
      end
   end

   // Apply sign and saturate; a bad fit gives a zero slope
   always_comb begin
      logic [QUO_W-1:0] q;
      logic             big;
      q   = dv_q_ff[QUO_W-1];
      big = dv_big_ff[QUO_W-1];
      if (dv_bad_ff[QUO_W-1]) begin
         slope_in = '0;
      end else if (!dv_neg_ff[QUO_W-1]) begin
         slope_in = (big || q[QUO_W-1]) ? {1'b0, {(SLOPE_W-1){1'b1}}} : q;
      end else if (big || (q > {1'b1, (QUO_W-1)'(0)})) begin
         slope_in = {1'b1, (SLOPE_W-1)'(0)};
      end else begin
         slope_in = ~q + SLOPE_W'(1);
      end
   end

   // Hold the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff.valid <= 1'b0;
      end else if (advance) begin
         out_ff.valid     <= dv_tag_ff[QUO_W-1].valid;
         out_ff.pixel     <= dv_tag_ff[QUO_W-1].pixel;
         out_ff.frame_end <= dv_tag_ff[QUO_W-1].frame_end;
         out_ff.slope     <= slope_in;
         out_ff.bad       <= dv_bad_ff[QUO_W-1];
      end
   end

   assign fit_out = out_ff;

endmodule
`default_nettype wire

// ===== design/utrsf_check.sv =====
// Port-level checks of the slope fit and their binding to the top level.
`default_nettype none
module utrsf_check (
   input wire        clock,
   input wire        reset,
   input wire        req_valid,
   input wire        req_ready,
   input wire        rsp_valid,
   input wire        rsp_ready,
   input wire [15:0] rsp_pixel_number,
   input wire [31:0] rsp_scaled_slope,
   input wire        rsp_bad_fit,
   input wire        rsp_frame_end
);

   // A held result keeps its valid
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // A held result keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_pixel_number) && $stable(rsp_scaled_slope)
         && $stable(rsp_bad_fit) && $stable(rsp_frame_end))
      else $error("response payload changed while stalled");

   // A failed fit reports a zero slope
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_fit |-> rsp_scaled_slope == 32'd0)
      else $error("bad fit with nonzero slope");

   // The request side only waits on a stalled result
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty result register");

   // Nothing comes out right after reset
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind up_the_ramp_slope_fit utrsf_check u_check (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req.valid),
   .req_ready        (req.ready),
   .rsp_valid        (rsp.valid),
   .rsp_ready        (rsp.ready),
   .rsp_pixel_number (rsp.pixel_number),
   .rsp_scaled_slope (rsp.scaled_slope),
   .rsp_bad_fit      (rsp.bad_fit),
   .rsp_frame_end    (rsp.frame_end)
);
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench of the up-the-ramp slope fit, with its slope predictor.
`default_nettype none

// Predicts each pixel's fitted slope and checks the block's results in order
class slope_predictor;
   typedef struct {
      logic [15:0] pixel;
      logic [31:0] slope;
      logic        bad;
      logic        frame_end;
   } slope_result_type;

   slope_result_type expected_slopes[$];
   logic [39:0]      time_sample_sum[65536];
   logic [23:0]      sample_sum[65536];
   logic [23:0]      time_sum;
   logic [39:0]      time_square_sum;
   logic [15:0]      first_time;
   logic [15:0]      current_time;
   int unsigned      pixel_pos;
   int unsigned      read_pos;
   int unsigned      pixel_count;
   int unsigned      read_count;
   int               errors;
   int               samples_seen;
   int               slopes_checked;
   int               bad_fits;

   function new();
      pixel_count = 65536;
      read_count  = 2;
   endfunction

   // Mirror a register write
   function void write_reg(utrsf_pkg::csr_index_type index, int unsigned value);
      if (index == utrsf_pkg::CSR_PIXEL_COUNT) pixel_count = value & 17'h1FFFF;
      else read_count = value & 9'h1FF;
   endfunction

   // Fold one accepted sample into the sums; queue a slope on the last read
   function void note_sample(logic [15:0] smp, logic [15:0] tim);
      int unsigned      eff_pixels, eff_reads;
      logic [15:0]      p;
      bit               last_pixel, last_read;
      longint           nr, num, den;
      int               span;
      logic [127:0]     mag, prod, quo;
      bit               neg;
      slope_result_type res;
      eff_pixels = pixel_count < 1 ? 1 : (pixel_count > 65536 ? 65536 : pixel_count);
      eff_reads  = read_count < 2 ? 2 : (read_count > 256 ? 256 : read_count);
      p          = pixel_pos[15:0];
      last_pixel = pixel_pos + 1 >= eff_pixels;
      last_read  = read_pos + 1 >= eff_reads;
      samples_seen++;
      // latch the read time from the first pixel
      if (pixel_pos == 0) begin
         current_time = tim;
         if (read_pos == 0) begin
            first_time      = tim;
            time_sum        = 24'(tim);
            time_square_sum = 40'(tim) * 40'(tim);
         end else begin
            time_sum        = time_sum + 24'(tim);
            time_square_sum = time_square_sum + 40'(tim) * 40'(tim);
         end
      end
      if (read_pos == 0) begin
         sample_sum[p]      = 24'(smp);
         time_sample_sum[p] = 40'(current_time) * 40'(smp);
      end else begin
         sample_sum[p]      = sample_sum[p] + 24'(smp);
         time_sample_sum[p] = time_sample_sum[p] + 40'(current_time) * 40'(smp);
      end
      // fit on the last read
      if (last_read) begin
         nr   = read_pos + 1;
         num  = nr * longint'(time_sample_sum[p]) - longint'(time_sum) * longint'(sample_sum[p]);
         den  = nr * longint'(time_square_sum) - longint'(time_sum) * longint'(time_sum);
         span = int'(current_time) - int'(first_time);
         res.pixel     = p;
         res.frame_end = last_pixel;
         res.slope     = '0;
         res.bad       = 1'b1;
         if (den > 0) begin
            mag  = num < 0 ? 128'(-num) : 128'(num);
            prod = mag * (128'(span < 0 ? -span : span) << 8);
            quo  = prod / 128'(den);
            neg  = (num < 0) != (span < 0);
            if (!neg) res.slope = quo > 128'h7FFFFFFF ? 32'h7FFFFFFF : quo[31:0];
            else res.slope = quo > 128'h80000000 ? 32'h80000000 : -quo[31:0];
            res.bad = 1'b0;
         end else begin
            bad_fits++;
         end
         expected_slopes.push_back(res);
      end
      // advance pixel and read positions
      if (last_pixel) begin
         pixel_pos = 0;
         read_pos  = last_read ? 0 : read_pos + 1;
      end else begin
         pixel_pos++;
      end
   endfunction

   // Compare one result against the oldest expectation
   function void check_slope(logic [15:0] pixel, logic [31:0] slope, logic bad,
                             logic frame_end);
      slope_result_type want;
      if (expected_slopes.size() == 0) begin
         $display("%0t: unexpected result pixel %0d slope %0d", $time, pixel, $signed(slope));
         errors++;
         return;
      end
      want = expected_slopes.pop_front();
      slopes_checked++;
      if (pixel !== want.pixel) begin
         $display("%0t: pixel_number expected %0d actual %0d", $time, want.pixel, pixel);
         errors++;
      end
      if (slope !== want.slope) begin
         $display("%0t: scaled_slope pixel %0d expected %0d actual %0d", $time, want.pixel,
                  $signed(want.slope), $signed(slope));
         errors++;
      end
      if (bad !== want.bad) begin
         $display("%0t: bad_fit pixel %0d expected %0b actual %0b", $time, want.pixel,
                  want.bad, bad);
         errors++;
      end
      if (frame_end !== want.frame_end) begin
         $display("%0t: frame_end pixel %0d expected %0b actual %0b", $time, want.pixel,
                  want.frame_end, frame_end);
         errors++;
      end
   endfunction
endclass

module tb_top;
   import utrsf_pkg::*;

   logic              clock;
   logic              reset;
   logic              csr_write_enable;
   logic [0:0]        csr_index;
   logic [CSR_W-1:0]  csr_write_data;

   utrsf_req_if req_ch();
   utrsf_rsp_if rsp_ch();

   slope_predictor fit_model = new();

   int send_idle_pct;
   int recv_idle_pct;
   int recv_hold_cycles;
   int eff_pix;
   int eff_rd;

   up_the_ramp_slope_fit dut (
      .clock            (clock),
      .reset            (reset),
      .req              (req_ch),
      .rsp              (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // Generate the clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Bound the run
   initial begin
      #30000000;
      $display("** up_the_ramp_slope_fit: FAILED **");
      $finish;
   end

   // Accept results with random back-pressure and long hold-offs
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready)
            fit_model.check_slope(rsp_ch.pixel_number, rsp_ch.scaled_slope,
                                  rsp_ch.bad_fit, rsp_ch.frame_end);
         if (recv_hold_cycles > 0) begin
            recv_hold_cycles--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= $urandom_range(99) >= recv_idle_pct;
         end
      end
   end

   // Write one register while the block is idle
   task automatic write_reg(csr_index_type index, int unsigned value);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= CSR_W'(value);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      fit_model.write_reg(index, value);
   endtask

   // Set both registers and track the effective frame and ramp sizes
   task automatic set_shape(int unsigned pixels, int unsigned reads);
      write_reg(CSR_PIXEL_COUNT, pixels);
      write_reg(CSR_READ_COUNT, reads);
      eff_pix = pixels < 1 ? 1 : (pixels > 65536 ? 65536 : pixels);
      eff_rd  = reads < 2 ? 2 : (reads > 256 ? 256 : reads);
   endtask

   // Offer one transaction, idling at random beforehand
   task automatic send_sample(logic [15:0] smp, logic [15:0] tim);
      if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.sample_value <= smp;
      req_ch.read_time    <= tim;
      do @(posedge clock); while (!req_ch.ready);
      fit_model.note_sample(smp, tim);
   endtask

   // Drop valid, drain all results, then let the pipeline empty
   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (fit_model.expected_slopes.size() > 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   // Send some reads of a ramp with a random time profile and sample shape
   task automatic send_reads(int first_read, int num_reads, int mode);
      logic [15:0] t;
      int          step;
      int          base;
      step = $urandom_range(0, 3000);
      base = $urandom_range(0, 65535 - step * eff_rd < 0 ? 0 : 65535 - step * eff_rd);
      for (int r = first_read; r < first_read + num_reads; r++) begin
         case (mode)
            0, 1, 2, 3, 4, 5, 6: t = 16'(base + step * r);
            7:                   t = 16'(base);
            default:             t = 16'($urandom);
         endcase
         for (int p = 0; p < eff_pix; p++)
            send_sample(mode == 4 ? 16'($urandom) : 16'(p * 37 + r * step / 4 + $urandom_range(0, 255)),
                        (p == 0 || $urandom_range(9) > 2) ? t : 16'($urandom));
      end
   endtask

   // Send ramps until the phase has enough samples
   task automatic send_ramps(int budget);
      int sent;
      sent = 0;
      while (sent < budget) begin
         send_reads(0, eff_rd, $urandom_range(0, 9));
         sent += eff_pix * eff_rd;
      end
   endtask

   initial begin
      int pix_tab[8];
      int rd_tab[8];
      pix_tab = '{0, 1, 9, 13, 1, 6, 17, 0};
      rd_tab  = '{1, 300, 5, 3, 511, 8, 2, 0};
      send_idle_pct       = 29;
      recv_idle_pct       = 50;
      recv_hold_cycles    = 0;
      reset               <= 1'b1;
      csr_write_enable    <= 1'b0;
      csr_index           <= CSR_PIXEL_COUNT;
      csr_write_data      <= '0;
      req_ch.valid        <= 1'b0;
      req_ch.sample_value <= '0;
      req_ch.read_time    <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: field extremes over three reads, then a flat-time ramp
      set_shape(4, 3);
      for (int r = 0; r < 3; r++) begin
         send_sample(16'h0000, r == 0 ? 16'h0000 : (r == 1 ? 16'd30000 : 16'hFFFF));
         send_sample(16'hFFFF, 16'h1234);
         send_sample(r == 0 ? 16'hFFFF : 16'h0000, 16'hFFFF);
         send_sample(16'(r * 21845), 16'h0000);
      end
      drain();
      set_shape(4, 2);
      for (int i = 0; i < 8; i++) send_sample(16'($urandom), 16'd4242);
      drain();

      // Random phases across register settings and idling modes
      for (int ph = 0; ph < 8; ph++) begin
         if (ph == 3) begin
            send_idle_pct = 50;
            recv_idle_pct = 29;
         end else if (ph == 6) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         if (ph == 7) set_shape($urandom_range(1, 24), $urandom_range(2, 10));
         else set_shape(pix_tab[ph], rd_tab[ph]);
         if (ph == 2) recv_hold_cycles = 400;
         // lower the read count mid-ramp so the ramp ends early
         if (ph == 5) begin
            send_reads(0, 2, 0);
            drain();
            write_reg(CSR_READ_COUNT, 3);
            eff_rd = 3;
            send_reads(2, 1, 0);
         end
         send_ramps(130);
         drain();
      end

      $display("Checked %0d slopes from %0d samples, %0d bad fits, register extremes and stalls.",
               fit_model.slopes_checked, fit_model.samples_seen, fit_model.bad_fits);
      if (fit_model.errors == 0 && fit_model.expected_slopes.size() == 0) begin
         $display("** up_the_ramp_slope_fit: PASSED **");
      end else begin
         $display("** up_the_ramp_slope_fit: FAILED **");
      end
      $finish;
   end
endmodule
`default_nettype wire
